@@ rtl/cbor_stream_decoder_unit_defines.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef CBOR_STREAM_DECODER_UNIT_DEFINES_SVH
`define CBOR_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define CSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbor decoder check failed");
// Next-cycle implication
`define CSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbor decoder check failed");
`else
`define CSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/csd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;

    localparam int CSD_MAX_DEPTH = 16;

    // event kinds
    localparam logic [3:0] EV_UINT     = 4'd0;
    localparam logic [3:0] EV_NEGINT   = 4'd1;
    localparam logic [3:0] EV_FALSE    = 4'd2;
    localparam logic [3:0] EV_NULL     = 4'd4;
    localparam logic [3:0] EV_F32      = 4'd5;
    localparam logic [3:0] EV_F64      = 4'd6;
    localparam logic [3:0] EV_BSTART   = 4'd7;
    localparam logic [3:0] EV_TSTART   = 4'd8;
    localparam logic [3:0] EV_DATA     = 4'd9;
    localparam logic [3:0] EV_STR_END  = 4'd10;
    localparam logic [3:0] EV_ARR      = 4'd11;
    localparam logic [3:0] EV_MAP      = 4'd12;
    localparam logic [3:0] EV_CONT_END = 4'd13;

    // status codes
    localparam logic [3:0] SC_OK        = 4'd0;
    localparam logic [3:0] SC_BAD_INFO  = 4'd1;
    localparam logic [3:0] SC_FLOAT16   = 4'd2;
    localparam logic [3:0] SC_BAD_SIMPLE = 4'd3;
    localparam logic [3:0] SC_BAD_CHUNK = 4'd4;
    localparam logic [3:0] SC_OVERFLOW  = 4'd5;
    localparam logic [3:0] SC_EARLY_END = 4'd6;
    localparam logic [3:0] SC_EXTRA     = 4'd7;
    localparam logic [3:0] SC_TOO_DEEP  = 4'd8;

    // major types
    localparam logic [2:0] MJ_UINT   = 3'd0;
    localparam logic [2:0] MJ_NEGINT = 3'd1;
    localparam logic [2:0] MJ_BYTES  = 3'd2;
    localparam logic [2:0] MJ_TEXT   = 3'd3;
    localparam logic [2:0] MJ_ARRAY  = 3'd4;
    localparam logic [2:0] MJ_MAP    = 3'd5;
    localparam logic [2:0] MJ_TAG    = 3'd6;
    localparam logic [2:0] MJ_SIMPLE = 3'd7;

    localparam logic [4:0] AI_INDEF  = 5'h1f;
    localparam logic [7:0] BREAK_BYTE = 8'hff;

    typedef enum logic [2:0] {
        MD_HEAD, MD_BYTES, MD_CHUNK_HEAD, MD_CHUNK_BYTES, MD_DONE
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_BYTE, S_DEC, S_STREND, S_CEND, S_POPRD, S_POPEM,
        S_FIN, S_FLUSH, S_END
    } t_state;

    // one stack frame
    typedef struct packed {
        logic        is_map;
        logic        open;
        logic [62:0] left;
        logic        wants_key;
    } t_frame;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] arg;
        logic        indef;
        logic [4:0]  depth;
        logic        key;
        logic        done;
        logic [3:0]  status;
        logic        last;
    } t_event;

    // total head length from the first byte, 0 for reserved info
    function automatic logic [3:0] head_need(input logic [7:0] b);
        logic [3:0] n;
        case (b[4:0])
            5'd24:   n = 4'd2;
            5'd25:   n = 4'd3;
            5'd26:   n = 4'd5;
            5'd27:   n = 4'd9;
            5'd28, 5'd29, 5'd30: n = 4'd0;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic t_event mk_ev(input logic [3:0] kind, input logic [63:0] arg,
                                     input logic indef, input logic [4:0] depth,
                                     input logic key, input logic [3:0] status);
        t_event e;
        e.kind   = kind;
        e.arg    = arg;
        e.indef  = indef;
        e.depth  = depth;
        e.key    = (status == SC_OK) ? key : 1'b0;
        e.done   = 1'b0;
        e.status = status;
        e.last   = 1'b0;
        return e;
    endfunction

endpackage
`default_nettype wire

@@ rtl/csd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module csd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/cbor_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake                 Payload
// input    i_in_valid / o_in_ready   i_in_byte, i_in_end
// output   o_out_valid / i_out_ready o_event_kind .. o_last
//
// Requests run one at a time, and output stalls can hold any of them. A byte
// dropped after a latched error stays in S_IDLE; an end mark passes S_END
// and S_FLUSH; other bytes pass S_LOAD, S_BYTE and S_FLUSH, plus S_DEC for a
// completed head. Finishing an item, a string or empty-container end, and
// each closed container (registered stack RAM read, S_POPRD) add states.
// Synchronous active-low reset; the frame RAM needs no clearing.
// A stalled output holds the pipeline in the event staging register.
// An end mark resets the decoder state for a new stream.
`include "cbor_stream_decoder_unit_defines.svh"
module cbor_stream_decoder_unit #(
    parameter int MAX_DEPTH = csd_pkg::CSD_MAX_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_end,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_event_kind,
    output logic [63:0]      o_event_arg,
    output logic             o_indefinite,
    output logic [4:0]       o_nest_depth,
    output logic             o_is_key,
    output logic             o_value_done,
    output logic [3:0]       o_status,
    output logic             o_last
);
    import csd_pkg::*;

    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FW  = $bits(t_frame);

    t_state       r_state, n_state;
    t_mode        r_mode, n_mode;
    logic [SPW-1:0] r_sp, n_sp;
    logic [3:0]   r_hc, n_hc;
    logic         r_err, n_err;
    logic [63:0]  r_pl, n_pl;
    logic [7:0]   r_b0, n_b0;
    logic [63:0]  r_arg, n_arg;
    logic [7:0]   r_byte, n_byte;
    t_frame       r_top, n_top;
    t_event       r_stg, n_stg;
    logic         r_pv, n_pv;
    t_event       r_out, n_out;
    logic         r_ovalid, n_ovalid;

    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_frame       ram_wdata, ram_rdata;
    logic [FW-1:0] ram_rbits;

    // frame stack
    csd_ram #(.WIDTH(FW), .DEPTH(MAX_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );
    assign ram_rdata = t_frame'(ram_rbits);

    // shared decode terms
    logic        in_acc, out_free, can_emit, sp_zero, key_top, key_rd;
    logic [4:0]  depth5;
    logic [AW-1:0] top_addr;
    logic [63:0] pl_dec;
    logic        brk, brk_pop;
    logic [3:0]  need_b, hc_inc;
    logic [2:0]  maj;
    logic [4:0]  inf;
    logic [63:0] dec_arg;
    logic        c_open;
    logic [62:0] left_dec;
    logic [SPW-1:0] sp_m1;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign can_emit = !r_pv || out_free;
    assign sp_zero  = (r_sp == '0);
    assign sp_m1    = r_sp - 1'b1;
    assign top_addr = sp_m1[AW-1:0];
    assign ram_raddr = top_addr;
    assign depth5   = 5'(r_sp);
    assign key_top  = !sp_zero && r_top.is_map && r_top.wants_key;
    assign key_rd   = !sp_zero && ram_rdata.is_map && ram_rdata.wants_key;
    assign pl_dec   = r_pl - {63'd0, (r_pl != 64'd0)};
    assign brk      = (r_hc == 4'd0) && (r_byte == BREAK_BYTE);
    assign brk_pop  = brk && (r_mode == MD_HEAD) && !sp_zero && r_top.open &&
                      (!r_top.is_map || r_top.wants_key);
    assign need_b   = head_need((r_hc == 4'd0) ? r_byte : r_b0);
    assign hc_inc   = r_hc + 4'd1;
    assign maj      = r_b0[7:5];
    assign inf      = r_b0[4:0];
    assign dec_arg  = (inf < 5'd24) ? {59'd0, inf} : r_arg;
    assign c_open   = (inf == AI_INDEF);
    assign left_dec = r_top.left - {62'd0, (r_top.left != 63'd0)};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_end) n_state = S_END;
                    else if (!r_err) n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_BYTE;
            S_BYTE: begin
                if (r_mode == MD_DONE) n_state = S_FLUSH;
                else if (r_mode == MD_BYTES || r_mode == MD_CHUNK_BYTES) begin
                    n_state = (pl_dec == 64'd0 && r_mode == MD_BYTES) ? S_STREND : S_FLUSH;
                end else if (brk && r_mode == MD_CHUNK_HEAD) n_state = S_FIN;
                else if (brk_pop) n_state = S_POPRD;
                else if (need_b == 4'd0) n_state = S_FLUSH;
                else if (hc_inc == need_b) n_state = S_DEC;
                else n_state = S_FLUSH;
            end
            S_DEC: begin
                n_state = S_FLUSH;
                if (r_mode != MD_CHUNK_HEAD) begin
                    case (maj)
                        MJ_UINT, MJ_NEGINT: if (!c_open) n_state = S_FIN;
                        MJ_SIMPLE: begin
                            if ((inf inside {[5'd20:5'd23]}) || inf == 5'd26 ||
                                inf == 5'd27) n_state = S_FIN;
                        end
                        MJ_BYTES, MJ_TEXT: if (!c_open && dec_arg == 64'd0) n_state = S_STREND;
                        MJ_ARRAY, MJ_MAP: begin
                            if (!c_open && !dec_arg[63] && r_sp < SPW'(MAX_DEPTH) &&
                                dec_arg == 64'd0) n_state = S_CEND;
                        end
                        default: n_state = S_FLUSH;
                    endcase
                end
            end
            S_STREND, S_CEND: if (can_emit) n_state = S_FIN;
            S_POPRD: n_state = S_POPEM;
            S_POPEM: if (can_emit) n_state = S_FIN;
            S_FIN: begin
                n_state = S_FLUSH;
                if (!sp_zero && !(r_top.is_map && r_top.wants_key) && !r_top.open &&
                    left_dec == 63'd0) n_state = S_POPRD;
            end
            S_FLUSH: if (!r_pv || out_free) n_state = S_IDLE;
            S_END: n_state = S_FLUSH;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and event production
    logic   e_req;
    t_event e_ev;
    t_frame f_new;
    always_comb begin
        n_mode = r_mode;  n_sp = r_sp;   n_hc = r_hc;   n_err = r_err;
        n_pl = r_pl;      n_b0 = r_b0;   n_arg = r_arg; n_top = r_top;
        n_byte = r_byte;  n_stg = r_stg; n_pv = r_pv;
        n_out = r_out;    n_ovalid = r_ovalid && !i_out_ready;
        ram_we = 1'b0;    ram_waddr = top_addr; ram_wdata = r_top;
        e_req = 1'b0;
        e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_OK);
        f_new = r_top;
        case (r_state)
            S_IDLE: if (in_acc) n_byte = i_in_byte;
            S_LOAD: n_top = ram_rdata;
            S_BYTE: begin
                if (r_mode == MD_DONE) begin
                    e_req = 1'b1; n_err = 1'b1;
                    e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_EXTRA);
                end else if (r_mode == MD_BYTES || r_mode == MD_CHUNK_BYTES) begin
                    e_req = 1'b1;
                    e_ev = mk_ev(EV_DATA, {56'd0, r_byte}, 1'b0, depth5, key_top, SC_OK);
                    n_pl = pl_dec;
                    if (pl_dec == 64'd0 && r_mode == MD_CHUNK_BYTES) n_mode = MD_CHUNK_HEAD;
                end else if (brk && r_mode == MD_CHUNK_HEAD) begin
                    e_req = 1'b1;
                    e_ev = mk_ev(EV_STR_END, 64'd0, 1'b0, depth5, key_top, SC_OK);
                end else if (brk_pop) begin
                    n_sp = sp_m1;
                end else begin
                    if (r_hc == 4'd0) begin
                        n_b0 = r_byte; n_arg = 64'd0;
                    end else begin
                        n_arg = {r_arg[55:0], r_byte};
                    end
                    if (need_b == 4'd0) begin
                        n_hc = 4'd0; e_req = 1'b1; n_err = 1'b1;
                        e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_BAD_INFO);
                    end else begin
                        n_hc = (hc_inc == need_b) ? 4'd0 : hc_inc;
                    end
                end
            end
            S_DEC: begin
                if (r_mode == MD_CHUNK_HEAD) begin
                    if (maj != MJ_BYTES && maj != MJ_TEXT) begin
                        e_req = 1'b1; n_err = 1'b1;
                        e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_BAD_CHUNK);
                    end else if (c_open) begin
                        e_req = 1'b1; n_err = 1'b1;
                        e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_BAD_INFO);
                    end else if (dec_arg != 64'd0) begin
                        n_pl = dec_arg; n_mode = MD_CHUNK_BYTES;
                    end
                end else begin
                    case (maj)
                        MJ_TAG: begin
                            if (c_open) begin
                                e_req = 1'b1; n_err = 1'b1;
                                e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_BAD_INFO);
                            end
                        end
                        MJ_UINT, MJ_NEGINT: begin
                            e_req = 1'b1;
                            if (c_open) begin
                                n_err = 1'b1;
                                e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_BAD_INFO);
                            end else begin
                                e_ev = mk_ev((maj == MJ_UINT) ? EV_UINT : EV_NEGINT, dec_arg,
                                             1'b0, depth5, key_top, SC_OK);
                            end
                        end
                        MJ_SIMPLE: begin
                            e_req = 1'b1;
                            if (inf inside {[5'd20:5'd23]}) begin
                                e_ev = mk_ev((inf == 5'd23) ? EV_NULL :
                                             (EV_FALSE + 4'(inf - 5'd20)), 64'd0, 1'b0,
                                             depth5, key_top, SC_OK);
                            end else if (inf == 5'd26) begin
                                e_ev = mk_ev(EV_F32, dec_arg, 1'b0, depth5, key_top, SC_OK);
                            end else if (inf == 5'd27) begin
                                e_ev = mk_ev(EV_F64, dec_arg, 1'b0, depth5, key_top, SC_OK);
                            end else begin
                                n_err = 1'b1;
                                e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0,
                                             (inf == 5'd25) ? SC_FLOAT16 : SC_BAD_SIMPLE);
                            end
                        end
                        MJ_BYTES, MJ_TEXT: begin
                            e_req = 1'b1;
                            e_ev = mk_ev((maj == MJ_BYTES) ? EV_BSTART : EV_TSTART,
                                         c_open ? 64'd0 : dec_arg, c_open, depth5,
                                         key_top, SC_OK);
                            if (c_open) n_mode = MD_CHUNK_HEAD;
                            else if (dec_arg != 64'd0) begin
                                n_pl = dec_arg; n_mode = MD_BYTES;
                            end
                        end
                        default: begin
                            e_req = 1'b1;
                            if (!c_open && dec_arg[63]) begin
                                n_err = 1'b1;
                                e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_OVERFLOW);
                            end else if (r_sp >= SPW'(MAX_DEPTH)) begin
                                n_err = 1'b1;
                                e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_TOO_DEEP);
                            end else begin
                                e_ev = mk_ev((maj == MJ_ARRAY) ? EV_ARR : EV_MAP,
                                             c_open ? 64'd0 : dec_arg, c_open, depth5,
                                             key_top, SC_OK);
                                if (c_open || dec_arg != 64'd0) begin
                                    // push new frame
                                    f_new.is_map    = (maj == MJ_MAP);
                                    f_new.open      = c_open;
                                    f_new.left      = c_open ? 63'd0 : dec_arg[62:0];
                                    f_new.wants_key = (maj == MJ_MAP);
                                    ram_we    = 1'b1;
                                    ram_waddr = r_sp[AW-1:0];
                                    ram_wdata = f_new;
                                    n_top     = f_new;
                                    n_sp      = r_sp + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            S_STREND: begin
                e_req = can_emit;
                e_ev = mk_ev(EV_STR_END, 64'd0, 1'b0, depth5, key_top, SC_OK);
            end
            S_CEND: begin
                e_req = can_emit;
                e_ev = mk_ev(EV_CONT_END, 64'd0, 1'b0, depth5, key_top, SC_OK);
            end
            S_POPEM: begin
                e_req = can_emit;
                e_ev = mk_ev(EV_CONT_END, 64'd0, 1'b0, depth5, key_rd, SC_OK);
                if (can_emit) n_top = ram_rdata;
            end
            S_FIN: begin
                n_mode = MD_HEAD;
                if (sp_zero) begin
                    n_mode = MD_DONE;
                    if (r_pv) n_stg.done = 1'b1;
                end else if (r_top.is_map && r_top.wants_key) begin
                    n_top.wants_key = 1'b0;
                    ram_we = 1'b1; ram_wdata = n_top;
                end else begin
                    if (r_top.is_map) n_top.wants_key = 1'b1;
                    if (!r_top.open) n_top.left = left_dec;
                    if (r_top.open || left_dec != 63'd0) begin
                        ram_we = 1'b1; ram_wdata = n_top;
                    end else begin
                        n_sp = sp_m1;
                    end
                end
            end
            S_FLUSH: begin
                if (r_pv && out_free) begin
                    n_out = r_stg; n_out.last = 1'b1;
                    n_ovalid = 1'b1; n_pv = 1'b0;
                end
            end
            S_END: begin
                if (!r_err && r_mode != MD_DONE) begin
                    e_req = 1'b1;
                    e_ev = mk_ev(EV_UINT, 64'd0, 1'b0, depth5, 1'b0, SC_EARLY_END);
                end
                n_sp = '0; n_mode = MD_HEAD; n_hc = 4'd0; n_pl = 64'd0; n_err = 1'b0;
            end
            default: ;
        endcase
        // move the older staged event out when a new one arrives
        if (e_req) begin
            if (r_pv) begin
                n_out = r_stg; n_out.last = 1'b0; n_ovalid = 1'b1;
            end
            n_stg = e_ev; n_pv = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MD_HEAD;
            r_sp     <= '0;
            r_hc     <= 4'd0;
            r_err    <= 1'b0;
            r_pl     <= 64'd0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_sp     <= n_sp;
            r_hc     <= n_hc;
            r_err    <= n_err;
            r_pl     <= n_pl;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_b0   <= n_b0;
        r_arg  <= n_arg;
        r_byte <= n_byte;
        r_top  <= n_top;
        r_stg  <= n_stg;
        r_out  <= n_out;
    end

    assign o_out_valid  = r_ovalid;
    assign o_event_kind = r_out.kind;
    assign o_event_arg  = r_out.arg;
    assign o_indefinite = r_out.indef;
    assign o_nest_depth = r_out.depth;
    assign o_is_key     = r_out.key;
    assign o_value_done = r_out.done;
    assign o_status     = r_out.status;
    assign o_last       = r_out.last;

    `CSD_ASSERT_SAME(a_ready_clean, i_clk, i_rst_n, o_in_ready, !r_pv)
    `CSD_ASSERT_SAME(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(MAX_DEPTH))
    `CSD_ASSERT_NEXT(a_err_quiet, i_clk, i_rst_n, in_acc && !i_in_end && r_err, r_state == S_IDLE && !r_pv)
    `CSD_ASSERT_NEXT(a_done_mark, i_clk, i_rst_n, r_state == S_FIN && sp_zero && r_pv, r_stg.done)
endmodule
`default_nettype wire
